// ----- src/stpat_pkg.sv -----
package stpat_pkg;

   localparam int PATTERN_MAX = 8;
   localparam int WIN_DEPTH   = PATTERN_MAX - 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] CSR_PATTERN_BYTES = 4'd0;
   localparam logic [3:0] CSR_PATTERN_LEN   = 4'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       not_found;
   } rsp_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_FOUND,
      TAIL_NOT_FOUND
   } tail_type;

   // one burst of results caused by one item
   typedef struct packed {
      logic [PATTERN_MAX-1:0][7:0] bytes;
      logic [3:0]                  nbytes;
      tail_type                    tail;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

endpackage

// ----- src/stream_truncate_at_pattern_unit.sv -----
// Passes a byte stream through until the first occurrence of the pattern set by
// the pattern_bytes and pattern_len registers, then drops the pattern and the
// rest of that stream; the final result carries found / not found. The front
// end takes one item per cycle, comparing the held window against the pattern in
// parallel, as long as the 4-entry burst queue has room. The back end delivers
// one result per cycle from the queue when rsp_ready allows, so an item that
// releases k results (k is 0 to 8, usually 0 or 1) holds the back end until
// all k are out. Results pass through the burst queue and then the output
// register of the back end. Write registers only while no stream is in flight.
module stream_truncate_at_pattern_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  stpat_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stpat_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [63:0]         csr_data
);
   import stpat_pkg::*;

   push_type push;
   desc_type head;
   logic     queue_full, queue_empty, pop;

   assign csr_ready = 1'b1;

   stpat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push)
   );

   stpat_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .empty (queue_empty),
      .head  (head)
   );

   stpat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/stpat_front.sv -----
module stpat_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  stpat_pkg::req_type  req_data,
   input  logic                csr_valid,
   input  logic [3:0]          csr_index,
   input  logic [63:0]         csr_data,
   input  logic                queue_full,
   output stpat_pkg::push_type push
);
   import stpat_pkg::*;

   logic [63:0] pat_ff;
   logic [3:0]  len_ff;
   logic [2:0]  held_ff, held_in;
   logic        matched_ff;
   logic [7:0]  window_ff [WIN_DEPTH];
   logic [7:0]  win_in    [WIN_DEPTH];

   logic [PATTERN_MAX-1:0][7:0] cand;
   logic [3:0] n, l_eff, n_m_l, count;
   logic       hit, eos, acc;

   assign eos       = req_data.end_of_stream;
   assign req_ready = !queue_full;
   assign acc       = req_valid && req_ready;

   always_comb begin
      logic [3:0] pos;
      logic [3:0] src;
      pos = '0;
      src = '0;
      if (len_ff == 4'd0) begin
         l_eff = 4'd1;
      end else if (len_ff > 4'(PATTERN_MAX)) begin
         l_eff = 4'(PATTERN_MAX);
      end else begin
         l_eff = len_ff;
      end

      for (int i = 0; i < WIN_DEPTH; i++) begin
         cand[i] = (3'(i) < held_ff) ? window_ff[i] : req_data.data_byte;
      end
      cand[PATTERN_MAX-1] = req_data.data_byte;

      n     = {1'b0, held_ff} + 4'd1;
      n_m_l = n - l_eff;
      hit   = (n >= l_eff);
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pos = n_m_l + 4'(i);
         if (4'(i) < l_eff && cand[pos[2:0]] != pat_ff[8*i +: 8]) begin
            hit = 1'b0;
         end
      end

      count   = (n > l_eff - 4'd1) ? n - (l_eff - 4'd1) : 4'd0;
      held_in = 3'(n - count);
      for (int j = 0; j < WIN_DEPTH; j++) begin
         src       = count + 4'(j);
         win_in[j] = cand[src[2:0]];
      end

      push.desc.bytes  = cand;
      push.desc.nbytes = count;
      push.desc.tail   = TAIL_NONE;
      push.valid       = 1'b0;
      if (acc && !matched_ff) begin
         if (hit) begin
            push.valid       = 1'b1;
            push.desc.nbytes = n_m_l;
            push.desc.tail   = TAIL_FOUND;
         end else if (eos) begin
            push.valid       = 1'b1;
            push.desc.nbytes = n;
            push.desc.tail   = TAIL_NOT_FOUND;
         end else begin
            push.valid = (count != 4'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff     <= '0;
         len_ff     <= 4'd1;
         held_ff    <= '0;
         matched_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_PATTERN_BYTES) begin
               pat_ff <= csr_data;
            end else if (csr_index == CSR_PATTERN_LEN) begin
               len_ff <= csr_data[3:0];
            end
         end
         if (acc) begin
            if (matched_ff) begin
               if (eos) begin
                  matched_ff <= 1'b0;
                  held_ff    <= '0;
               end
            end else if (hit) begin
               held_ff    <= '0;
               matched_ff <= !eos;
            end else if (eos) begin
               held_ff <= '0;
            end else begin
               held_ff <= held_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         window_ff <= win_in;
      end
   end

endmodule

// ----- src/stpat_queue.sv -----
module stpat_queue (
   input  logic                clock,
   input  logic                reset,
   input  stpat_pkg::push_type push,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output stpat_pkg::desc_type head
);
   import stpat_pkg::*;

   desc_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   cnt_ff;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.desc;
      end
   end

endmodule

// ----- src/stpat_back.sv -----
module stpat_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  stpat_pkg::desc_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stpat_pkg::rsp_type  rsp_data
);
   import stpat_pkg::*;

   logic [2:0] idx_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, item;
   logic [3:0] total;
   logic       load, at_end;

   assign total  = head.nbytes + ((head.tail == TAIL_FOUND) ? 4'd1 : 4'd0);
   assign at_end = ({1'b0, idx_ff} == total - 4'd1);
   assign load   = !empty && (!rsp_valid_ff || rsp_ready);
   assign pop    = load && at_end;

   always_comb begin
      if ({1'b0, idx_ff} < head.nbytes) begin
         item.out_byte  = head.bytes[idx_ff];
         item.has_byte  = 1'b1;
         item.run_last  = (head.tail == TAIL_NOT_FOUND) && at_end;
         item.not_found = (head.tail == TAIL_NOT_FOUND) && at_end;
      end else begin
         item.out_byte  = '0;
         item.has_byte  = 1'b0;
         item.run_last  = 1'b1;
         item.not_found = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= at_end ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/stpat_checker.sv -----
module stpat_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input stpat_pkg::rsp_type rsp_data
);
   import stpat_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_byte |->
         rsp_data.run_last && !rsp_data.not_found && rsp_data.out_byte == 8'd0)
      else $error("bad status-only result");

   a_not_found_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.not_found |-> rsp_data.run_last && rsp_data.has_byte)
      else $error("not_found on non-final result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stream_truncate_at_pattern_unit stpat_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
